>>> hw/rtl/bfa_pkg.sv
// shared constants, types and the find result struct for the bitmap frame allocator
// no dependencies; used by bfa_lsb_find and bitmap_frame_allocator_unit

package bfa_pkg;

   localparam int ADDR_BITS       = 32;
   localparam int FRAME_BYTES     = 4096;
   localparam int FRAME_SHIFT     = 12;
   localparam int FRAME_LIMIT     = 32768;
   localparam int MAP_WORD_BITS   = 32;
   localparam int BIT_SEL_BITS    = 5;
   localparam int MAP_WORDS       = FRAME_LIMIT / MAP_WORD_BITS;
   localparam int WORD_ADDR_BITS  = 10;
   localparam int GROUP_BITS      = WORD_ADDR_BITS - BIT_SEL_BITS;
   localparam int GROUPS          = MAP_WORDS / MAP_WORD_BITS;
   localparam int FRAME_IDX_BITS  = WORD_ADDR_BITS + BIT_SEL_BITS;
   localparam int COUNT_BITS      = 16;
   localparam int REQ_IDX_BITS    = ADDR_BITS - FRAME_SHIFT;

   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEMORY_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESERVED_END = 2'd1;

   localparam logic [ADDR_BITS-1:0] MEMORY_SIZE_RESET  = 32'd134217728;
   localparam logic [ADDR_BITS-1:0] RESERVED_END_RESET = 32'd0;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef logic [MAP_WORD_BITS-1:0] map_word_type;

   typedef struct packed {
      logic                    found;
      logic [BIT_SEL_BITS-1:0] index;
   } find_result_type;

endpackage

>>> hw/rtl/bfa_lsb_find.sv
// lowest-set-bit finder over one map word, the shared search unit of the allocator
// depends on bfa_pkg

module bfa_lsb_find (
   input  bfa_pkg::map_word_type    vec,
   output bfa_pkg::find_result_type result
);

   always_comb begin
      result.found = |vec;
      result.index = '0;
      for (int i = bfa_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            result.index = bfa_pkg::BIT_SEL_BITS'(i);
         end
      end
   end

endmodule

>>> hw/rtl/bitmap_frame_allocator_unit.sv
// top level of the bitmap first-fit frame allocator: sequencer, map and summary memories
// depends on bfa_pkg and bfa_lsb_find

// One used/free bit per 4 KiB frame sits in a 1024 x 32 map memory; a 32 x 32 summary
// memory has one bit per map word that holds a free frame, and 32 flip-flops flag the
// summary words that are not empty. A transaction is taken when start is high and busy
// is low; its result shows on rsp_* for exactly one cycle with rsp_strobe high, and the
// receiver has to take it then. An alloc transaction searches the group flags, then the
// summary word, then the map word, all with the single lowest-set-bit unit; a free
// transaction does a read-modify-write of map and summary; a failed alloc or an
// out-of-range free answers straight from the idle state. The strobe rises in the
// cycle after the last step. After reset and after every write to register 0 or 1 the
// map is rebuilt by a pass over all map words with busy high, one map word per cycle.
// Configuration writes are taken at any time and restart that pass; writes to other
// indexes are ignored.

module bitmap_frame_allocator_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [bfa_pkg::ADDR_BITS-1:0]      req_release_address,
   // result channel
   output logic                               rsp_strobe,
   output logic [bfa_pkg::ADDR_BITS-1:0]      rsp_frame_address,
   output logic                               rsp_success,
   // configuration port
   input  logic                               csr_we,
   input  logic [bfa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bfa_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_INIT,
      S_CLEAR,
      S_IDLE,
      S_ALLOC_SUM,
      S_ALLOC_MAP,
      S_FREE
   } state_type;

   // control and registered outputs
   state_type                               state_ff;
   logic [bfa_pkg::WORD_ADDR_BITS-1:0]      ptr_ff;
   logic [bfa_pkg::WORD_ADDR_BITS-1:0]      word_ff;
   logic [bfa_pkg::BIT_SEL_BITS-1:0]        bit_ff;
   bfa_pkg::map_word_type                   acc_ff;
   logic [bfa_pkg::GROUPS-1:0]              group_ff;
   logic [bfa_pkg::COUNT_BITS-1:0]          fc_ff;
   logic [bfa_pkg::COUNT_BITS-1:0]          first_ff;
   logic [bfa_pkg::ADDR_BITS-1:0]           mem_size_ff;
   logic [bfa_pkg::ADDR_BITS-1:0]           reserved_ff;
   logic                                    rsp_strobe_ff;
   logic [bfa_pkg::ADDR_BITS-1:0]           rsp_address_ff;
   logic                                    rsp_success_ff;

   // memories and their registered read data
   bfa_pkg::map_word_type map_mem [bfa_pkg::MAP_WORDS];
   bfa_pkg::map_word_type sum_mem [bfa_pkg::GROUPS];
   bfa_pkg::map_word_type map_rd_ff;
   bfa_pkg::map_word_type sum_rd_ff;

   logic [bfa_pkg::WORD_ADDR_BITS-1:0] map_raddr_in;
   logic [bfa_pkg::GROUP_BITS-1:0]     sum_raddr_in;
   logic                               map_we_in;
   logic [bfa_pkg::WORD_ADDR_BITS-1:0] map_waddr_in;
   bfa_pkg::map_word_type              map_wdata_in;
   logic                               sum_we_in;
   logic [bfa_pkg::GROUP_BITS-1:0]     sum_waddr_in;
   bfa_pkg::map_word_type              sum_wdata_in;

   // shared search unit
   bfa_pkg::map_word_type    find_vec;
   bfa_pkg::find_result_type find_res;

   bfa_lsb_find u_find (
      .vec    (find_vec),
      .result (find_res)
   );

   // request decode
   logic [bfa_pkg::REQ_IDX_BITS-1:0] req_idx;
   logic                             req_in_range;
   logic                             cfg_hit;

   assign req_idx      = req_release_address[bfa_pkg::ADDR_BITS-1:bfa_pkg::FRAME_SHIFT];
   assign req_in_range = req_idx < bfa_pkg::REQ_IDX_BITS'(fc_ff);
   assign cfg_hit      = csr_we && (csr_index == bfa_pkg::CSR_MEMORY_SIZE ||
                                    csr_index == bfa_pkg::CSR_RESERVED_END);

   // frame count and first free frame from the configuration
   logic [bfa_pkg::REQ_IDX_BITS-1:0]  fc_raw;
   logic [bfa_pkg::COUNT_BITS-1:0]    fc_calc;
   logic [bfa_pkg::ADDR_BITS:0]       res_round;
   logic [bfa_pkg::REQ_IDX_BITS:0]    first_raw;
   logic [bfa_pkg::COUNT_BITS-1:0]    first_calc;

   always_comb begin
      fc_raw  = mem_size_ff[bfa_pkg::ADDR_BITS-1:bfa_pkg::FRAME_SHIFT];
      fc_calc = (fc_raw > bfa_pkg::REQ_IDX_BITS'(bfa_pkg::FRAME_LIMIT))
              ? bfa_pkg::COUNT_BITS'(bfa_pkg::FRAME_LIMIT)
              : bfa_pkg::COUNT_BITS'(fc_raw);
      // round up without wrap, then cap at the frame count
      res_round  = {1'b0, reserved_ff} + (bfa_pkg::ADDR_BITS + 1)'(bfa_pkg::FRAME_BYTES - 1);
      first_raw  = res_round[bfa_pkg::ADDR_BITS:bfa_pkg::FRAME_SHIFT];
      first_calc = (first_raw > (bfa_pkg::REQ_IDX_BITS + 1)'(fc_calc))
                 ? fc_calc : bfa_pkg::COUNT_BITS'(first_raw);
   end

   // free bits of the map word under the rebuild pointer
   logic [bfa_pkg::GROUP_BITS + bfa_pkg::WORD_ADDR_BITS - bfa_pkg::BIT_SEL_BITS:0] ptr_ext;
   logic [bfa_pkg::COUNT_BITS-bfa_pkg::BIT_SEL_BITS-1:0] first_hi;
   logic [bfa_pkg::COUNT_BITS-bfa_pkg::BIT_SEL_BITS-1:0] fc_hi;
   logic [bfa_pkg::COUNT_BITS-bfa_pkg::BIT_SEL_BITS-1:0] ptr_cmp;
   bfa_pkg::map_word_type ge_mask;
   bfa_pkg::map_word_type lt_mask;
   bfa_pkg::map_word_type free_mask;
   bfa_pkg::map_word_type acc_next;

   always_comb begin
      ptr_ext  = '0;
      ptr_cmp  = (bfa_pkg::COUNT_BITS - bfa_pkg::BIT_SEL_BITS)'(ptr_ff);
      first_hi = first_ff[bfa_pkg::COUNT_BITS-1:bfa_pkg::BIT_SEL_BITS];
      fc_hi    = fc_ff[bfa_pkg::COUNT_BITS-1:bfa_pkg::BIT_SEL_BITS];
      if (ptr_cmp > first_hi) begin
         ge_mask = '1;
      end else if (ptr_cmp == first_hi) begin
         ge_mask = '1 << first_ff[bfa_pkg::BIT_SEL_BITS-1:0];
      end else begin
         ge_mask = '0;
      end
      if (ptr_cmp < fc_hi) begin
         lt_mask = '1;
      end else if (ptr_cmp == fc_hi) begin
         lt_mask = ~('1 << fc_ff[bfa_pkg::BIT_SEL_BITS-1:0]);
      end else begin
         lt_mask = '0;
      end
      free_mask = ge_mask & lt_mask | bfa_pkg::map_word_type'(ptr_ext);
      acc_next  = acc_ff | (bfa_pkg::map_word_type'(|free_mask)
                            << ptr_ff[bfa_pkg::BIT_SEL_BITS-1:0]);
   end

   // search input, read addresses and write ports
   bfa_pkg::map_word_type onehot_word;
   bfa_pkg::map_word_type onehot_find;
   bfa_pkg::map_word_type map_set;
   bfa_pkg::map_word_type sum_clr;

   always_comb begin
      onehot_word = bfa_pkg::map_word_type'(1) << word_ff[bfa_pkg::BIT_SEL_BITS-1:0];
      onehot_find = bfa_pkg::map_word_type'(1) << find_res.index;
      map_set     = map_rd_ff | onehot_find;
      sum_clr     = sum_rd_ff & ~onehot_word;

      find_vec     = '0;
      map_raddr_in = word_ff;
      sum_raddr_in = word_ff[bfa_pkg::WORD_ADDR_BITS-1:bfa_pkg::BIT_SEL_BITS];
      map_we_in    = 1'b0;
      map_waddr_in = word_ff;
      map_wdata_in = map_set;
      sum_we_in    = 1'b0;
      sum_waddr_in = word_ff[bfa_pkg::WORD_ADDR_BITS-1:bfa_pkg::BIT_SEL_BITS];
      sum_wdata_in = sum_clr;

      case (state_ff)
         S_CLEAR: begin
            map_we_in    = 1'b1;
            map_waddr_in = ptr_ff;
            map_wdata_in = ~free_mask;
            sum_we_in    = &ptr_ff[bfa_pkg::BIT_SEL_BITS-1:0];
            sum_waddr_in = ptr_ff[bfa_pkg::WORD_ADDR_BITS-1:bfa_pkg::BIT_SEL_BITS];
            sum_wdata_in = acc_next;
         end
         S_IDLE: begin
            // group flags are searched here, the summary word is read at the edge
            find_vec     = bfa_pkg::map_word_type'(group_ff);
            map_raddr_in = req_idx[bfa_pkg::WORD_ADDR_BITS + bfa_pkg::BIT_SEL_BITS - 1:
                                   bfa_pkg::BIT_SEL_BITS];
            sum_raddr_in = (req_op == bfa_pkg::OP_FREE)
                         ? req_idx[bfa_pkg::FRAME_IDX_BITS-1:bfa_pkg::WORD_ADDR_BITS]
                         : find_res.index;
         end
         S_ALLOC_SUM: begin
            find_vec     = sum_rd_ff;
            map_raddr_in = {word_ff[bfa_pkg::WORD_ADDR_BITS-1:bfa_pkg::BIT_SEL_BITS],
                            find_res.index};
         end
         S_ALLOC_MAP: begin
            // lowest free frame: lowest zero of the used bits
            find_vec     = ~map_rd_ff;
            map_we_in    = 1'b1;
            map_wdata_in = map_set;
            sum_we_in    = &map_set;
            sum_wdata_in = sum_clr;
         end
         S_FREE: begin
            map_we_in    = 1'b1;
            map_wdata_in = map_rd_ff & ~(bfa_pkg::map_word_type'(1) << bit_ff);
            sum_we_in    = 1'b1;
            sum_wdata_in = sum_rd_ff | onehot_word;
         end
         default: begin
            find_vec = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (map_we_in) begin
         map_mem[map_waddr_in] <= map_wdata_in;
      end
      map_rd_ff <= map_mem[map_raddr_in];
   end

   always_ff @(posedge clock) begin
      if (sum_we_in) begin
         sum_mem[sum_waddr_in] <= sum_wdata_in;
      end
      sum_rd_ff <= sum_mem[sum_raddr_in];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         ptr_ff         <= '0;
         acc_ff         <= '0;
         group_ff       <= '0;
         mem_size_ff    <= bfa_pkg::MEMORY_SIZE_RESET;
         reserved_ff    <= bfa_pkg::RESERVED_END_RESET;
         rsp_strobe_ff  <= 1'b0;
         rsp_success_ff <= 1'b0;
         rsp_address_ff <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_INIT: begin
               fc_ff    <= fc_calc;
               first_ff <= first_calc;
               ptr_ff   <= '0;
               acc_ff   <= '0;
               state_ff <= S_CLEAR;
            end
            S_CLEAR: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (&ptr_ff[bfa_pkg::BIT_SEL_BITS-1:0]) begin
                  acc_ff <= '0;
                  group_ff[ptr_ff[bfa_pkg::WORD_ADDR_BITS-1:bfa_pkg::BIT_SEL_BITS]] <=
                     |acc_next;
               end else begin
                  acc_ff <= acc_next;
               end
               if (&ptr_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  rsp_address_ff <= '0;
                  if (req_op == bfa_pkg::OP_FREE) begin
                     word_ff <= req_idx[bfa_pkg::FRAME_IDX_BITS-1:bfa_pkg::BIT_SEL_BITS];
                     bit_ff  <= req_idx[bfa_pkg::BIT_SEL_BITS-1:0];
                     if (req_in_range) begin
                        state_ff <= S_FREE;
                     end else begin
                        rsp_strobe_ff  <= 1'b1;
                        rsp_success_ff <= 1'b0;
                     end
                  end else begin
                     word_ff <= {find_res.index, bfa_pkg::BIT_SEL_BITS'(0)};
                     if (find_res.found) begin
                        state_ff <= S_ALLOC_SUM;
                     end else begin
                        // memory exhausted
                        rsp_strobe_ff  <= 1'b1;
                        rsp_success_ff <= 1'b0;
                     end
                  end
               end
            end
            S_ALLOC_SUM: begin
               word_ff[bfa_pkg::BIT_SEL_BITS-1:0] <= find_res.index;
               state_ff <= S_ALLOC_MAP;
            end
            S_ALLOC_MAP: begin
               if ((&map_set) && !(|sum_clr)) begin
                  group_ff[word_ff[bfa_pkg::WORD_ADDR_BITS-1:bfa_pkg::BIT_SEL_BITS]] <= 1'b0;
               end
               rsp_strobe_ff  <= 1'b1;
               rsp_success_ff <= 1'b1;
               rsp_address_ff <= bfa_pkg::ADDR_BITS'({word_ff, find_res.index})
                                 << bfa_pkg::FRAME_SHIFT;
               state_ff       <= S_IDLE;
            end
            S_FREE: begin
               group_ff[word_ff[bfa_pkg::WORD_ADDR_BITS-1:bfa_pkg::BIT_SEL_BITS]] <= 1'b1;
               rsp_strobe_ff  <= 1'b1;
               rsp_success_ff <= 1'b1;
               rsp_address_ff <= '0;
               state_ff       <= S_IDLE;
            end
            default: begin
               state_ff <= S_INIT;
            end
         endcase
         // a configuration write restarts the rebuild
         if (cfg_hit) begin
            if (csr_index == bfa_pkg::CSR_MEMORY_SIZE) begin
               mem_size_ff <= csr_wdata;
            end else begin
               reserved_ff <= csr_wdata;
            end
            state_ff <= S_INIT;
         end
      end
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_frame_address = rsp_address_ff;
   assign rsp_success       = rsp_success_ff;

   // a group flag set means its summary word holds a free map word
   a_sum_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC_SUM |-> (|sum_rd_ff))
      else $error("summary word empty under a set group flag");

   // a summary bit set means the map word holds a free frame
   a_map_has_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC_MAP |-> !(&map_rd_ff))
      else $error("selected map word has no free frame");

   // results only appear once the sequencer is back at rest
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == S_IDLE)
      else $error("result strobe outside idle");

   // an accepted transaction either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe || busy)
      else $error("accepted transaction dropped");

endmodule

>>> dv/bfa_allocation_checker.sv
`timescale 1ns / 100ps
// frame allocator checker: watches request, result and register ports, keeps its own bitmap
// and compares every result with the oldest predicted grant; depends on bfa_pkg

module bfa_allocation_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_op,
   input  logic [bfa_pkg::ADDR_BITS-1:0]      req_release_address,
   input  logic                               rsp_strobe,
   input  logic [bfa_pkg::ADDR_BITS-1:0]      rsp_frame_address,
   input  logic                               rsp_success,
   input  logic                               csr_we,
   input  logic [bfa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bfa_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 error_count,
   output int                                 outstanding
);

   typedef struct {
      logic [bfa_pkg::ADDR_BITS-1:0] frame_address;
      logic                          success;
   } grant_type;

   bfa_pkg::map_word_type         used_words [bfa_pkg::MAP_WORDS];
   int unsigned                   live_frames;
   logic [bfa_pkg::ADDR_BITS-1:0] mem_bytes;
   logic [bfa_pkg::ADDR_BITS-1:0] reserved_end;
   grant_type                     expected_grants [$];
   int                            errors;
   int                            results_seen;

   // all frames used, then the range from the rounded-up reserved end to the count freed
   function automatic void rebuild_usage();
      logic [bfa_pkg::ADDR_BITS:0] first_free;
      int unsigned                 lo;
      int unsigned                 raw;
      raw         = mem_bytes >> bfa_pkg::FRAME_SHIFT;
      live_frames = (raw > bfa_pkg::FRAME_LIMIT) ? bfa_pkg::FRAME_LIMIT : raw;
      foreach (used_words[w]) used_words[w] = '1;
      first_free = ({1'b0, reserved_end}
                    + (bfa_pkg::ADDR_BITS + 1)'(bfa_pkg::FRAME_BYTES - 1))
                   >> bfa_pkg::FRAME_SHIFT;
      lo = (first_free > live_frames) ? live_frames : 32'(first_free);
      for (int unsigned f = lo; f < live_frames; f++)
         used_words[f / bfa_pkg::MAP_WORD_BITS][f % bfa_pkg::MAP_WORD_BITS] = 1'b0;
   endfunction

   // first-fit claim or release, updates the bitmap
   function automatic grant_type predict_grant(logic                          op,
                                               logic [bfa_pkg::ADDR_BITS-1:0] addr);
      grant_type   g;
      int unsigned fidx;
      int unsigned frame;
      g.frame_address = '0;
      g.success       = 1'b0;
      if (op == bfa_pkg::OP_ALLOC) begin
         for (int w = 0; w < bfa_pkg::MAP_WORDS && !g.success; w++) begin
            if (used_words[w] != '1) begin
               for (int b = 0; b < bfa_pkg::MAP_WORD_BITS; b++) begin
                  frame = w * bfa_pkg::MAP_WORD_BITS + b;
                  if (!g.success && !used_words[w][b] && frame < live_frames) begin
                     used_words[w][b] = 1'b1;
                     g.frame_address  = frame * bfa_pkg::FRAME_BYTES;
                     g.success        = 1'b1;
                  end
               end
            end
         end
      end else begin
         fidx = addr >> bfa_pkg::FRAME_SHIFT;
         if (fidx < live_frames) begin
            used_words[fidx / bfa_pkg::MAP_WORD_BITS][fidx % bfa_pkg::MAP_WORD_BITS] = 1'b0;
            g.success = 1'b1;
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         mem_bytes    = bfa_pkg::MEMORY_SIZE_RESET;
         reserved_end = bfa_pkg::RESERVED_END_RESET;
         rebuild_usage();
         expected_grants.delete();
      end else begin
         if (rsp_strobe) begin
            results_seen++;
            if (expected_grants.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result %0d: frame_address %08h success %0b",
                           results_seen, rsp_frame_address, rsp_success);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_frame_address !== want.frame_address ||
                   rsp_success !== want.success) begin
                  errors++;
                  if (errors <= 10)
                     $display(
                        "result %0d mismatch: address exp %08h got %08h, success exp %0b got %0b",
                        results_seen, want.frame_address, rsp_frame_address,
                        want.success, rsp_success);
               end
            end
         end
         if (start && !busy)
            expected_grants.push_back(predict_grant(req_op, req_release_address));
         if (csr_we) begin
            case (csr_index)
               bfa_pkg::CSR_MEMORY_SIZE: begin
                  mem_bytes = csr_wdata;
                  rebuild_usage();
               end
               bfa_pkg::CSR_RESERVED_END: begin
                  reserved_end = csr_wdata;
                  rebuild_usage();
               end
               default: ;
            endcase
         end
      end
      error_count <= errors;
      outstanding <= expected_grants.size();
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// testbench top for the bitmap frame allocator: clock, reset, stimulus and verdict
// depends on bfa_pkg, bitmap_frame_allocator_unit and bfa_allocation_checker

module tb;

   // rebuild passes dominate: about 15 of them, plus ~570 short transactions
   localparam int CYCLE_LIMIT = 300000;
   // first register index with nothing behind it
   localparam logic [bfa_pkg::CSR_INDEX_BITS-1:0] CSR_NO_REG = 2'd2;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic                               req_op;
   logic [bfa_pkg::ADDR_BITS-1:0]      req_release_address;
   logic                               rsp_strobe;
   logic [bfa_pkg::ADDR_BITS-1:0]      rsp_frame_address;
   logic                               rsp_success;
   logic                               csr_we;
   logic [bfa_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [bfa_pkg::CSR_DATA_BITS-1:0]  csr_wdata;
   int                                 error_count;
   int                                 outstanding;

   int          cycles = 0;
   bit          steady;       // no idling on the request side
   int unsigned frames_now;   // current frame count, only to aim free addresses
   int          allocs;
   int          frees;
   int          writes;

   bitmap_frame_allocator_unit u_top (.*);
   bfa_allocation_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case a result never shows up
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int unsigned frames_of(logic [bfa_pkg::ADDR_BITS-1:0] bytes);
      int unsigned raw;
      raw = bytes >> bfa_pkg::FRAME_SHIFT;
      return (raw > bfa_pkg::FRAME_LIMIT) ? bfa_pkg::FRAME_LIMIT : raw;
   endfunction

   // leaves csr_we high; the caller drops it after the last write
   task automatic write_reg(logic [bfa_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [bfa_pkg::CSR_DATA_BITS-1:0]  data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      writes++;
      if (idx == bfa_pkg::CSR_MEMORY_SIZE) frames_now = frames_of(data);
   endtask

   // hold off until every result is back, then a few cycles of slack
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // new memory layout, only written while the allocator is idle
   task automatic configure(logic [bfa_pkg::ADDR_BITS-1:0] mem,
                            logic [bfa_pkg::ADDR_BITS-1:0] res_end,
                            bit reserved_first, bit stray);
      drain();
      if (stray)
         write_reg(bfa_pkg::CSR_INDEX_BITS'(CSR_NO_REG + $urandom_range(1)), $urandom());
      if (reserved_first) begin
         write_reg(bfa_pkg::CSR_RESERVED_END, res_end);
         write_reg(bfa_pkg::CSR_MEMORY_SIZE, mem);
      end else begin
         write_reg(bfa_pkg::CSR_MEMORY_SIZE, mem);
         write_reg(bfa_pkg::CSR_RESERVED_END, res_end);
      end
      csr_we <= 1'b0;
   endtask

   // start stays high after acceptance so back-to-back transactions need no extra edge
   task automatic send(logic op, logic [bfa_pkg::ADDR_BITS-1:0] addr);
      while (!steady && $urandom_range(99) < 27) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start               <= 1'b1;
      req_op              <= op;
      req_release_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == bfa_pkg::OP_ALLOC) allocs++;
      else frees++;
   endtask

   // mostly allocs and frees of plausible frames, some wild addresses
   task automatic random_item();
      int unsigned pick;
      int unsigned span;
      pick = $urandom_range(99);
      span = (frames_now > 64 && $urandom_range(1)) ? 64 : frames_now + 1;
      if (pick < 55)
         send(bfa_pkg::OP_ALLOC, $urandom());
      else if (pick < 88)
         send(bfa_pkg::OP_FREE, ($urandom_range(span) << bfa_pkg::FRAME_SHIFT)
                                | $urandom_range(bfa_pkg::FRAME_BYTES - 1));
      else
         send(bfa_pkg::OP_FREE, $urandom());
   endtask

   initial begin
      logic [bfa_pkg::ADDR_BITS-1:0] mem;
      logic [bfa_pkg::ADDR_BITS-1:0] res_end;
      int unsigned                   fr;
      int unsigned                   r;

      reset               = 1'b1;
      start               = 1'b0;
      req_op              = bfa_pkg::OP_ALLOC;
      req_release_address = '0;
      csr_we              = 1'b0;
      csr_index           = bfa_pkg::CSR_MEMORY_SIZE;
      csr_wdata           = '0;
      steady              = 1'b0;
      frames_now          = frames_of(bfa_pkg::MEMORY_SIZE_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset layout: full 32768 frames, nothing reserved
      send(bfa_pkg::OP_ALLOC, 32'hFFFF_FFFF);      // frame zero comes back as address zero
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      send(bfa_pkg::OP_FREE, 32'h0000_0FFF);       // offset bits inside the frame are ignored
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      send(bfa_pkg::OP_FREE, 32'h0800_0000);       // first frame past the count
      send(bfa_pkg::OP_FREE, 32'hFFFF_FFFF);
      send(bfa_pkg::OP_FREE, 32'h07FF_FFFF);       // last frame, already free
      send(bfa_pkg::OP_FREE, 32'h0000_1000);

      // reserved end past memory: nothing free, capped frame count
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);      // exhausted
      send(bfa_pkg::OP_FREE, 32'h0000_0000);       // freeing a reserved frame still works
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);

      // no memory at all, plus a write to an index with no register
      configure(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      send(bfa_pkg::OP_FREE, 32'h0000_0000);

      // three frames with a partial last page, reserved end rounds up to frame 1
      configure(32'h0000_3FFF, 32'h0000_0001, 1'b0, 1'b0);
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      send(bfa_pkg::OP_FREE, 32'h0000_2ABC);
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      send(bfa_pkg::OP_FREE, 32'h0000_0000);
      send(bfa_pkg::OP_ALLOC, 32'h0000_0000);

      // random phases, each under its own layout, mostly small enough to run dry
      for (int p = 0; p < 11; p++) begin
         r = $urandom_range(9);
         if (r < 6) begin
            mem = ($urandom_range(80) << bfa_pkg::FRAME_SHIFT)
                  | $urandom_range(bfa_pkg::FRAME_BYTES - 1);
         end else if (r < 8) begin
            mem = $urandom();
         end else if (r == 8) begin
            mem = 32'hFFFF_FFFF;
         end else begin
            mem = $urandom_range(bfa_pkg::FRAME_BYTES - 1);
         end
         fr = frames_of(mem);
         if (fr > 100) fr = 100;
         r = $urandom_range(5);
         if (r < 2) begin
            res_end = ($urandom_range(fr + 2) << bfa_pkg::FRAME_SHIFT)
                      | $urandom_range(bfa_pkg::FRAME_BYTES - 1);
         end else if (r == 2) begin
            // exact page boundary
            res_end = $urandom_range(fr + 2) << bfa_pkg::FRAME_SHIFT;
         end else if (r == 3) begin
            res_end = '0;
         end else if (r == 4) begin
            res_end = 32'hFFFF_FFFF;
         end else begin
            res_end = $urandom();
         end
         configure(mem, res_end, 1'($urandom_range(1)), $urandom_range(2) == 0);

         steady = (p == 2);
         for (int i = 0; i < 50; i++) begin
            if (p == 5 && i == 25) drain();   // let the pipeline run empty mid-phase
            random_item();
         end
      end
      steady = 1'b0;

      drain();
      repeat (4) @(posedge clock);
      $display("summary: %0d alloc and %0d free transactions over %0d register writes,",
               allocs, frees, writes);
      $display("summary: empty, tiny, capped and fully reserved memories with exhaustion");
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
